// File: sv/atan2_pkg.sv
// ----------------------------------------------------------------------------
// atan2 package
// Widths, Q2.30 constants and the stage-to-stage types.
// ----------------------------------------------------------------------------
`default_nettype none

package atan2_pkg;

    localparam int IN_W      = 16;
    localparam int MAG_W     = IN_W + 1;
    localparam int RATIO_W   = 16;
    localparam int M_W       = RATIO_W + 1;
    localparam int FRAC_W    = 12;
    localparam int ANGLE_W   = 15;
    localparam int V_W       = 34;
    localparam int SH        = 30 - FRAC_W;
    localparam int DIV_STEPS = RATIO_W + 1;

    localparam logic [31:0] Q30_QUARTER_PI = 32'd843314857;
    localparam logic [31:0] Q30_COEF_A     = 32'd262744624;
    localparam logic [31:0] Q30_COEF_B     = 32'd71189083;
    localparam logic signed [V_W-1:0] Q30_HALF_PI = 34'sd1686629713;
    localparam logic signed [V_W-1:0] Q30_PI      = 34'sd3373259426;
    localparam logic [M_W-1:0] RATIO_ONE = M_W'(1) << RATIO_W;

    // flags that ride along with the quotient
    typedef struct packed {
        logic x_zero;
        logic y_zero;
        logic y_neg;
        logic x_neg;
        logic swap;
        logic neg;
    } t_flags;

    // divider stage contents
    typedef struct packed {
        t_flags             flags;
        logic [MAG_W-1:0]   den;
        logic [MAG_W+M_W-1:0] rem;   // shifted remainder
        logic [M_W-1:0]     quo;
    } t_div;

endpackage

`default_nettype wire

// File: sv/atan2_div.sv
// ----------------------------------------------------------------------------
// atan2 ratio divider
// Restoring divider, one quotient bit per pipeline stage, gives num/den in Q16.
// ----------------------------------------------------------------------------
`default_nettype none

module atan2_div import atan2_pkg::*; (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_valid,
    input  wire logic signed [IN_W-1:0] i_y_value,
    input  wire logic signed [IN_W-1:0] i_x_value,
    output logic                o_valid,
    output t_flags              o_flags,
    output logic [M_W-1:0]      o_m
);

    logic [DIV_STEPS:0] r_vld;
    t_div               r_st [DIV_STEPS+1];
    t_div               n_in;
    logic [MAG_W-1:0]   ay, ax;

    always_comb begin
        ay = i_y_value[IN_W-1] ? MAG_W'(-$signed({i_y_value[IN_W-1], i_y_value}))
                               : MAG_W'({1'b0, i_y_value});
        ax = i_x_value[IN_W-1] ? MAG_W'(-$signed({i_x_value[IN_W-1], i_x_value}))
                               : MAG_W'({1'b0, i_x_value});
        n_in.flags.x_zero = (i_x_value == '0);
        n_in.flags.y_zero = (i_y_value == '0);
        n_in.flags.y_neg  = i_y_value[IN_W-1];
        n_in.flags.x_neg  = i_x_value[IN_W-1];
        n_in.flags.swap   = ay > ax;
        n_in.flags.neg    = i_y_value[IN_W-1] != i_x_value[IN_W-1];
        n_in.den = (ay > ax) ? ay : ax;
        // numerator placed so each stage shifts in one bit
        n_in.rem = (MAG_W+M_W)'((ay > ax) ? ax : ay);
        n_in.quo = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[DIV_STEPS-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0] <= n_in;
        end
    end

    // stage k: rem holds partial remainder, quotient bits enter from the right
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [MAG_W:0] trial;
        logic           fits;
        assign trial = {1'b0, r_st[k].rem[MAG_W-1:0]};
        assign fits  = (k == 0) ? (trial >= {1'b0, r_st[k].den})
                                : ({r_st[k].rem[MAG_W-1:0], 1'b0} >= {1'b0, r_st[k].den});
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[k+1].flags <= r_st[k].flags;
                r_st[k+1].den   <= r_st[k].den;
                r_st[k+1].quo   <= {r_st[k].quo[M_W-2:0], fits};
                if (k == 0) begin
                    r_st[k+1].rem <= fits
                        ? (MAG_W+M_W)'(r_st[k].rem[MAG_W-1:0] - r_st[k].den)
                        : r_st[k].rem;
                end else begin
                    r_st[k+1].rem <= fits
                        ? (MAG_W+M_W)'(MAG_W'({r_st[k].rem[MAG_W-1:0], 1'b0})
                                       - r_st[k].den)
                        : (MAG_W+M_W)'(MAG_W'({r_st[k].rem[MAG_W-1:0], 1'b0}));
                end
            end
        end
    end

    assign o_valid = r_vld[DIV_STEPS];
    assign o_flags = r_st[DIV_STEPS].flags;
    assign o_m     = r_st[DIV_STEPS].quo;

endmodule

`default_nettype wire

// File: sv/atan2_poly.sv
// ----------------------------------------------------------------------------
// atan2 polynomial and quadrant fix
// P(m) = pi/4*m + m(1-m)(A + B m), then sign, reflection, pi shift, rounding.
// ----------------------------------------------------------------------------
`default_nettype none

module atan2_poly import atan2_pkg::*; (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_valid,
    input  wire t_flags         i_flags,
    input  wire logic [M_W-1:0] i_m,
    output logic                o_valid,
    output logic [ANGLE_W-1:0]  o_angle
);

    logic [3:0]  r_vld;
    t_flags      r_f1, r_f2;
    // stage 1: three products of m
    logic [31:0] r_lin;
    logic [M_W-1:0] r_w;
    logic [31:0] r_c;
    // stage 2: bend product
    logic [31:0] r_lin2;
    logic [31:0] r_bend;
    // stage 3: signed angle
    logic signed [V_W-1:0] r_v;
    // stage 4: rounded
    logic [ANGLE_W-1:0] r_angle;

    logic [48:0] lin_p, cb_p, bend_p;
    logic [33:0] w_p;
    logic signed [V_W-1:0] p_s, v_a, v_b, v_c;
    logic [V_W-1:0] v_rnd;

    always_comb begin
        lin_p  = 49'(Q30_QUARTER_PI) * 49'(i_m);
        w_p    = 34'(i_m) * 34'(RATIO_ONE - i_m);
        cb_p   = 49'(Q30_COEF_B) * 49'(i_m);
        bend_p = 49'(r_w) * 49'(r_c);
        p_s = V_W'({1'b0, r_lin2}) + V_W'({1'b0, r_bend});
        v_a = r_f2.neg ? -p_s : p_s;
        v_b = r_f2.swap ? ((r_f2.neg ? -Q30_HALF_PI : Q30_HALF_PI) - v_a) : v_a;
        v_c = r_f2.x_neg ? (r_f2.y_neg ? v_b - Q30_PI : v_b + Q30_PI) : v_b;
        if (r_f2.x_zero) begin
            v_c = r_f2.y_zero ? '0 : (r_f2.y_neg ? -Q30_HALF_PI : Q30_HALF_PI);
        end
        // arithmetic shift after adding half an lsb gives ties toward +inf
        v_rnd = V_W'(r_v + (V_W'(1) <<< (SH - 1))) ;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f1   <= i_flags;
            r_lin  <= 32'(lin_p >> RATIO_W);
            r_w    <= M_W'(w_p >> RATIO_W);
            r_c    <= Q30_COEF_A + 32'(cb_p >> RATIO_W);
            r_f2   <= r_f1;
            r_lin2 <= r_lin;
            r_bend <= 32'(bend_p >> RATIO_W);
            r_v    <= v_c;
            r_angle <= ANGLE_W'($signed(v_rnd) >>> SH);
        end
    end

    assign o_valid = r_vld[3];
    assign o_angle = r_angle;

endmodule

`default_nettype wire

// File: sv/atan2_poly_approx.sv
// throughput: one word per cycle while the output is not stalled; 17 divider stages, one quotient bit each,
// then four stages for polynomial products, quadrant fix and rounding
// the whole pipeline advances together and holds while the output waits
// reset: synchronous active low, clears all valid bits; data is not reset
// ----------------------------------------------------------------------------
// atan2 polynomial approximation
// Four-quadrant arctangent of a signed pair, Q3.12 radians.
// ----------------------------------------------------------------------------
`default_nettype none

module atan2_poly_approx import atan2_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic signed [IN_W-1:0] i_y_value,
    input  wire logic signed [IN_W-1:0] i_x_value,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic signed [ANGLE_W-1:0]   o_angle
);

    logic         en;
    logic         div_vld, poly_vld;
    t_flags       div_f;
    logic [M_W-1:0] div_m;
    logic [ANGLE_W-1:0] poly_angle;

    // pipeline moves when the output register is empty or being drained
    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    atan2_div u_div (
        .i_clk, .i_rst_n, .i_en(en), .i_valid,
        .i_y_value, .i_x_value,
        .o_valid(div_vld), .o_flags(div_f), .o_m(div_m)
    );

    atan2_poly u_poly (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(div_vld),
        .i_flags(div_f), .i_m(div_m),
        .o_valid(poly_vld), .o_angle(poly_angle)
    );

    assign o_valid = poly_vld;
    assign o_angle = $signed(poly_angle);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_angle))
        else $error("result changed while stalled");
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("not ready with empty output");
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("valid after reset");

endmodule

`default_nettype wire
